>>> rtl/pixel_sample_accumulator_unit_assert.svh
// assertion macros for the pixel sample accumulator checker
// expects clk and rst_n in the scope of each use
`ifndef PIXEL_SAMPLE_ACCUMULATOR_UNIT_ASSERT_SVH
`define PIXEL_SAMPLE_ACCUMULATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define PSA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/psa_pkg.sv
// shared types and constants of the pixel sample accumulator
// no dependencies
package psa_pkg;

    localparam int SUM_W     = 40;
    localparam int SAMPLE_W  = 24;
    localparam int COORD_W   = 16;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_CNT_W = 16;
    localparam int STATUS_W  = 2;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 9'd256;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 2'd1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OUTSIDE   = 2'd1,
        STAT_NONFINITE = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_DIVIDE
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic lookup;
        logic commit;
        logic div_start;
        logic div_load;
    } psa_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic needs_div;
        logic div_done;
        logic out_busy;
    } psa_flags_t;

endpackage

>>> rtl/psa_div.sv
// bit-serial signed-by-unsigned divider, one quotient bit per cycle
// result truncated toward zero and saturated to the sample range; uses psa_pkg
module psa_div #(
    parameter int DIVW = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [psa_pkg::SUM_W-1:0]     dividend,
    input  logic [DIVW-1:0]               divisor,
    output logic                          done,
    output logic [psa_pkg::SAMPLE_W-1:0]  quotient
);
    import psa_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam logic [STEP_W-1:0] STEPS     = STEP_W'(SUM_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(1);
    localparam logic [SUM_W-1:0]  POS_LIMIT = SUM_W'(2 ** (SAMPLE_W - 1) - 1);
    localparam logic [SUM_W-1:0]  NEG_LIMIT = SUM_W'(2 ** (SAMPLE_W - 1));

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              neg_reg;
    logic [SUM_W-1:0]  work_reg;
    logic [DIVW-1:0]   rem_reg;
    logic [DIVW-1:0]   div_reg;

    logic [DIVW:0]     rem_shift;
    logic [DIVW:0]     rem_sub;
    logic              fits;
    logic [DIVW-1:0]   rem_step;
    logic [SUM_W-1:0]  mag_sat;

    assign rem_shift = {rem_reg, work_reg[SUM_W-1]};
    assign fits      = rem_shift >= {1'b0, div_reg};
    assign rem_sub   = rem_shift - {1'b0, div_reg};
    // remainder stays below the divisor, so the top bit is always clear
    assign rem_step  = fits ? rem_sub[DIVW-1:0] : rem_shift[DIVW-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            step_next = STEPS;
        end
        else if (busy_reg)
        begin
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= dividend[SUM_W-1];
            work_reg <= dividend[SUM_W-1] ? (~dividend) + SUM_W'(1) : dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[SUM_W-2:0], fits};
            rem_reg  <= rem_step;
        end
    end

    always_comb
    begin
        if (neg_reg)
        begin
            mag_sat  = (work_reg > NEG_LIMIT) ? NEG_LIMIT : work_reg;
            quotient = (~mag_sat[SAMPLE_W-1:0]) + SAMPLE_W'(1);
        end
        else
        begin
            mag_sat  = (work_reg > POS_LIMIT) ? POS_LIMIT : work_reg;
            quotient = mag_sat[SAMPLE_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

>>> rtl/psa_datapath.sv
// datapath: config registers, pixel memory, clear sweep, update logic,
// three divider lanes and the output register; uses psa_pkg and psa_div
module psa_datapath #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int COUNT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [psa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [psa_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                func,
    input  logic signed [psa_pkg::COORD_W-1:0]  pixel_x,
    input  logic signed [psa_pkg::COORD_W-1:0]  pixel_y,
    input  logic signed [psa_pkg::SAMPLE_W-1:0] sample_red,
    input  logic signed [psa_pkg::SAMPLE_W-1:0] sample_green,
    input  logic signed [psa_pkg::SAMPLE_W-1:0] sample_blue,
    input  logic                                sample_finite,
    input  psa_pkg::psa_cmd_t                   cmd,
    output psa_pkg::psa_flags_t                 flags,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [psa_pkg::SAMPLE_W-1:0] avg_red,
    output logic signed [psa_pkg::SAMPLE_W-1:0] avg_green,
    output logic signed [psa_pkg::SAMPLE_W-1:0] avg_blue,
    output logic [psa_pkg::OUT_CNT_W-1:0]       samples_in_pixel,
    output logic [psa_pkg::STATUS_W-1:0]        status
);
    import psa_pkg::*;

    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int ENTRY_W = 3 * SUM_W + COUNT_BITS;
    localparam int CMP_W   = COORD_W + 1;

    localparam logic [CMP_W-1:0]      MAX_W_C    = CMP_W'(MAX_WIDTH);
    localparam logic [CMP_W-1:0]      MAX_H_C    = CMP_W'(MAX_HEIGHT);
    localparam logic [ADDR_W-1:0]     ROW_STEP   = ADDR_W'(MAX_WIDTH);
    localparam logic [ADDR_W-1:0]     LAST_ADDR  = ADDR_W'(DEPTH - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

    // configuration
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ACTIVE_RESET;
            height_reg <= ACTIVE_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_ACTIVE_WIDTH)
                width_reg <= cfg_data;
            else if (cfg_index == REG_ACTIVE_HEIGHT)
                height_reg <= cfg_data;
        end
    end

    // frame test and address for the incoming beat
    logic [CMP_W-1:0]  x_mag, y_mag;
    logic              lookup_inside;
    logic [ADDR_W-1:0] lookup_addr;

    assign x_mag = CMP_W'(pixel_x[COORD_W-2:0]);
    assign y_mag = CMP_W'(pixel_y[COORD_W-2:0]);
    assign lookup_inside = !pixel_x[COORD_W-1] && !pixel_y[COORD_W-1]
                        && (x_mag < CMP_W'(width_reg)) && (x_mag < MAX_W_C)
                        && (y_mag < CMP_W'(height_reg)) && (y_mag < MAX_H_C);
    assign lookup_addr = ADDR_W'(pixel_y[YW-1:0]) * ROW_STEP + ADDR_W'(pixel_x[XW-1:0]);

    // registered item
    logic                 func_reg;
    logic [SAMPLE_W-1:0]  red_reg, green_reg, blue_reg;
    logic                 finite_reg;
    logic                 inside_reg;
    logic [ADDR_W-1:0]    addr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            func_reg   <= func;
            red_reg    <= sample_red;
            green_reg  <= sample_green;
            blue_reg   <= sample_blue;
            finite_reg <= sample_finite;
            inside_reg <= lookup_inside;
            addr_reg   <= lookup_addr;
        end
    end

    // clear sweep after reset
    logic [ADDR_W-1:0] clr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clear_step)
            clr_reg <= clr_reg + ADDR_W'(1);
    end

    // pixel memory: red, green, blue sums then count
    logic [ENTRY_W-1:0]    mem [DEPTH];
    logic [ENTRY_W-1:0]    rd_reg;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_wa;
    logic [ENTRY_W-1:0]    mem_wd;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (cmd.lookup)
            rd_reg <= mem[lookup_addr];
    end

    logic [SUM_W-1:0]      rd_red, rd_green, rd_blue;
    logic [COUNT_BITS-1:0] rd_cnt;

    assign rd_red   = rd_reg[ENTRY_W-1 -: SUM_W];
    assign rd_green = rd_reg[ENTRY_W-SUM_W-1 -: SUM_W];
    assign rd_blue  = rd_reg[ENTRY_W-2*SUM_W-1 -: SUM_W];
    assign rd_cnt   = rd_reg[COUNT_BITS-1:0];

    // update and result selection
    logic                  is_read;
    logic                  add_ok;
    logic [SUM_W-1:0]      new_red, new_green, new_blue;
    logic [COUNT_BITS-1:0] cnt_inc;
    status_t               eval_status;
    logic [COUNT_BITS-1:0] eval_cnt;

    assign is_read   = func_reg == FUNC_READ;
    assign add_ok    = inside_reg && !is_read && finite_reg && (rd_cnt != COUNT_FULL);
    assign new_red   = rd_red   + {{(SUM_W-SAMPLE_W){red_reg[SAMPLE_W-1]}}, red_reg};
    assign new_green = rd_green + {{(SUM_W-SAMPLE_W){green_reg[SAMPLE_W-1]}}, green_reg};
    assign new_blue  = rd_blue  + {{(SUM_W-SAMPLE_W){blue_reg[SAMPLE_W-1]}}, blue_reg};
    assign cnt_inc   = rd_cnt + COUNT_BITS'(1);

    always_comb
    begin
        if (!inside_reg)
        begin
            eval_status = STAT_OUTSIDE;
            eval_cnt    = '0;
        end
        else if (is_read)
        begin
            eval_status = STAT_OK;
            eval_cnt    = rd_cnt;
        end
        else if (!finite_reg)
        begin
            eval_status = STAT_NONFINITE;
            eval_cnt    = rd_cnt;
        end
        else if (rd_cnt == COUNT_FULL)
        begin
            eval_status = STAT_FULL;
            eval_cnt    = rd_cnt;
        end
        else
        begin
            eval_status = STAT_OK;
            eval_cnt    = cnt_inc;
        end
    end

    assign mem_we = cmd.clear_step || (cmd.commit && add_ok);
    assign mem_wa = cmd.clear_step ? clr_reg : addr_reg;
    assign mem_wd = cmd.clear_step ? '0 : {new_red, new_green, new_blue, cnt_inc};

    // divider lanes
    logic                done_red, done_green, done_blue;
    logic [SAMPLE_W-1:0] q_red, q_green, q_blue;

    psa_div #(.DIVW(COUNT_BITS)) u_div_red (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rd_red),
        .divisor  (rd_cnt),
        .done     (done_red),
        .quotient (q_red)
    );

    psa_div #(.DIVW(COUNT_BITS)) u_div_green (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rd_green),
        .divisor  (rd_cnt),
        .done     (done_green),
        .quotient (q_green)
    );

    psa_div #(.DIVW(COUNT_BITS)) u_div_blue (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rd_blue),
        .divisor  (rd_cnt),
        .done     (done_blue),
        .quotient (q_blue)
    );

    // output register
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_red_reg, out_green_reg, out_blue_reg;
    logic [OUT_CNT_W-1:0] out_cnt_reg;
    status_t             out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit || cmd.div_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_red_reg    <= '0;
            out_green_reg  <= '0;
            out_blue_reg   <= '0;
            out_cnt_reg    <= OUT_CNT_W'(eval_cnt);
            out_status_reg <= eval_status;
        end
        else if (cmd.div_load)
        begin
            out_red_reg    <= q_red;
            out_green_reg  <= q_green;
            out_blue_reg   <= q_blue;
            out_cnt_reg    <= OUT_CNT_W'(rd_cnt);
            out_status_reg <= STAT_OK;
        end
    end

    assign flags.clear_last = clr_reg == LAST_ADDR;
    assign flags.needs_div  = inside_reg && is_read && (rd_cnt != '0);
    assign flags.div_done   = done_red && done_green && done_blue;
    assign flags.out_busy   = out_valid_reg && out_stall;

    assign out_valid        = out_valid_reg;
    assign avg_red          = out_red_reg;
    assign avg_green        = out_green_reg;
    assign avg_blue         = out_blue_reg;
    assign samples_in_pixel = out_cnt_reg;
    assign status           = out_status_reg;

endmodule

>>> rtl/psa_ctrl.sv
// controller: sequences the clear sweep, lookup, update and divide steps
// uses psa_pkg
module psa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  psa_pkg::psa_flags_t flags,
    output psa_pkg::psa_cmd_t   cmd
);
    import psa_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (flags.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.lookup = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                // memory word is in the read register now
                if (flags.needs_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
                else if (!flags.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIVIDE:
            begin
                if (flags.div_done && !flags.out_busy)
                begin
                    cmd.div_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

>>> rtl/pixel_sample_accumulator_unit.sv
// top level of the pixel sample accumulator: film buffer of per-pixel rgb sums
// and sample counts; uses psa_pkg, psa_ctrl, psa_datapath
//
// After reset the buffer is zeroed by a sweep over all MAX_WIDTH*MAX_HEIGHT
// pixel words (one pixel word a cycle) during which in_stall stays high;
// config writes are taken at any time. An add beat reads the pixel word from
// the memory when the beat is taken; in the evaluation step the updated sums
// and count are written back and the result is loaded. A read beat of a pixel
// with samples has the same lookup and evaluation steps, then runs three
// parallel bit-serial dividers (one quotient bit of the 40-bit sum per cycle)
// and then loads the result. Reads outside the frame or of empty pixels load
// their result in the evaluation step. A result waiting in the output
// register does not block the next input beat from being taken, but that
// beat's write-back and result load wait until the waiting result is taken.
module pixel_sample_accumulator_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int COUNT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [psa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [psa_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                func,
    input  logic signed [psa_pkg::COORD_W-1:0]  pixel_x,
    input  logic signed [psa_pkg::COORD_W-1:0]  pixel_y,
    input  logic signed [psa_pkg::SAMPLE_W-1:0] sample_red,
    input  logic signed [psa_pkg::SAMPLE_W-1:0] sample_green,
    input  logic signed [psa_pkg::SAMPLE_W-1:0] sample_blue,
    input  logic                                sample_finite,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [psa_pkg::SAMPLE_W-1:0] avg_red,
    output logic signed [psa_pkg::SAMPLE_W-1:0] avg_green,
    output logic signed [psa_pkg::SAMPLE_W-1:0] avg_blue,
    output logic [psa_pkg::OUT_CNT_W-1:0]       samples_in_pixel,
    output logic [psa_pkg::STATUS_W-1:0]        status
);
    import psa_pkg::*;

    psa_cmd_t   cmd;
    psa_flags_t flags;

    psa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .flags    (flags),
        .cmd      (cmd)
    );

    psa_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .func             (func),
        .pixel_x          (pixel_x),
        .pixel_y          (pixel_y),
        .sample_red       (sample_red),
        .sample_green     (sample_green),
        .sample_blue      (sample_blue),
        .sample_finite    (sample_finite),
        .cmd              (cmd),
        .flags            (flags),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .avg_red          (avg_red),
        .avg_green        (avg_green),
        .avg_blue         (avg_blue),
        .samples_in_pixel (samples_in_pixel),
        .status           (status)
    );

endmodule

>>> rtl/psa_checker.sv
// port-level checker for the pixel sample accumulator, bound to the top level
// uses psa_pkg and pixel_sample_accumulator_unit_assert.svh
`include "pixel_sample_accumulator_unit_assert.svh"

module psa_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [psa_pkg::SAMPLE_W-1:0] avg_red,
    input logic signed [psa_pkg::SAMPLE_W-1:0] avg_green,
    input logic signed [psa_pkg::SAMPLE_W-1:0] avg_blue,
    input logic [psa_pkg::OUT_CNT_W-1:0]       samples_in_pixel,
    input logic [psa_pkg::STATUS_W-1:0]        status
);
    import psa_pkg::*;

    // a stalled result beat holds
    `PSA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(avg_red) && $stable(avg_green) && $stable(avg_blue) && $stable(samples_in_pixel) && $stable(status), "result beat changed while stalled")

    // one item in flight: a taken input beat stalls the next cycle
    `PSA_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "input taken back to back")

    // outside the frame everything reads as zero
    `PSA_ASSERT_IMPLY(a_outside_zero, out_valid && status == STAT_OUTSIDE, samples_in_pixel == '0 && avg_red == '0 && avg_green == '0 && avg_blue == '0, "outside result not zero")

    // rejected adds carry no averages
    `PSA_ASSERT_IMPLY(a_reject_zero, out_valid && (status == STAT_NONFINITE || status == STAT_FULL), avg_red == '0 && avg_green == '0 && avg_blue == '0, "rejected add with nonzero average")

endmodule

bind pixel_sample_accumulator_unit psa_checker u_checker (.*);
